### rtl/trie_pkg.sv
package trie_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam int         KIND_PREFIX_BIT = 1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
        logic       empty_word;
    } t_in_item;

    typedef struct packed {
        logic answer;
        logic table_full;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHILD,
        ST_MARK
    } t_state;

endpackage

### rtl/trie_insert_lookup_core.sv
// Each character transfer does the child table read and then the cursor update.
// After the final character, an exact search goes on to read the word end mark.
// An empty word skips the child table read. One word is handled at a time.
// Reset starts a clearing pass over the child table and the word end marks.
// No input transfer is taken during that pass.
module trie_insert_lookup_core #(
    parameter int NODES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  trie_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output trie_pkg::t_out_item  o_out_data
);
    import trie_pkg::*;

    localparam int         NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int         AW = NW + 8;
    localparam int         DEPTH = NODES * 256;
    localparam logic [NW:0] NODES_W = (NW + 1)'(NODES);

    logic [NW-1:0] r_child_mem [0:DEPTH-1];
    logic          r_mark_mem  [0:NODES-1];

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [NW:0]   r_nodes_used, n_nodes_used;
    logic [NW-1:0] r_cursor, n_cursor;
    logic          r_path_lost, n_path_lost;
    logic          r_overflowed, n_overflowed;
    logic [1:0]    r_word_kind, n_word_kind;
    logic          r_mid_word, n_mid_word;
    logic [AW-1:0] r_slot, n_slot;
    logic          r_last, n_last;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;
    logic [NW-1:0] r_child_rdata;
    logic          r_mark_rdata;

    logic          accept;
    logic          start;
    logic [1:0]    kind_eff;
    logic [NW-1:0] cur_eff;
    logic          lost_eff;
    logic          ovf_eff;
    logic          ins_eff;
    logic          exact_eff;
    logic          ins_word;
    logic          exact_word;
    logic [NW-1:0] cur_new;
    logic          lost_new;
    logic          ovf_new;
    logic          alloc_now;

    logic          child_we;
    logic [AW-1:0] child_waddr;
    logic [NW-1:0] child_wdata;
    logic          child_re;
    logic [AW-1:0] child_raddr;
    logic          mark_we;
    logic [NW-1:0] mark_waddr;
    logic          mark_wdata;
    logic          mark_re;
    logic [NW-1:0] mark_raddr;

    assign o_in_stall  = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign start     = !r_mid_word;
    assign kind_eff  = start ? i_in_data.kind : r_word_kind;
    assign cur_eff   = start ? '0 : r_cursor;
    assign lost_eff  = start ? 1'b0 : r_path_lost;
    assign ovf_eff   = start ? 1'b0 : r_overflowed;
    assign ins_eff   = (kind_eff == KIND_INSERT);
    assign exact_eff = !ins_eff && !kind_eff[KIND_PREFIX_BIT];

    assign ins_word   = (r_word_kind == KIND_INSERT);
    assign exact_word = !ins_word && !r_word_kind[KIND_PREFIX_BIT];

    // One step down the trie from the child table entry just read.
    always_comb begin
        cur_new   = r_cursor;
        lost_new  = r_path_lost;
        ovf_new   = r_overflowed;
        alloc_now = 1'b0;
        if (ins_word) begin
            if (!r_overflowed) begin
                if (r_child_rdata == '0) begin
                    if (r_nodes_used < NODES_W) begin
                        alloc_now = 1'b1;
                        cur_new   = r_nodes_used[NW-1:0];
                    end else begin
                        ovf_new = 1'b1;
                    end
                end else begin
                    cur_new = r_child_rdata;
                end
            end
        end else if (!r_path_lost) begin
            if (r_child_rdata == '0) begin
                lost_new = 1'b1;
            end else begin
                cur_new = r_child_rdata;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == {AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (!i_in_data.empty_word) begin
                        n_state = ST_CHILD;
                    end else if (exact_eff) begin
                        n_state = ST_MARK;
                    end
                end
            end
            ST_CHILD: begin
                if (r_last && exact_word) begin
                    n_state = ST_MARK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MARK: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_clr_addr   = r_clr_addr;
        n_nodes_used = r_nodes_used;
        n_cursor     = r_cursor;
        n_path_lost  = r_path_lost;
        n_overflowed = r_overflowed;
        n_word_kind  = r_word_kind;
        n_mid_word   = r_mid_word;
        n_slot       = r_slot;
        n_last       = r_last;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        child_we     = 1'b0;
        child_waddr  = r_slot;
        child_wdata  = '0;
        child_re     = 1'b0;
        child_raddr  = {cur_eff, i_in_data.ch};
        mark_we      = 1'b0;
        mark_waddr   = r_cursor;
        mark_wdata   = 1'b1;
        mark_re      = 1'b0;
        mark_raddr   = r_cursor;
        case (r_state)
            ST_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = r_clr_addr;
                mark_we     = 1'b1;
                mark_waddr  = r_clr_addr[AW-1:8];
                mark_wdata  = 1'b0;
                n_clr_addr  = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_word_kind  = kind_eff;
                    n_cursor     = cur_eff;
                    n_path_lost  = lost_eff;
                    n_overflowed = ovf_eff;
                    n_last       = i_in_data.last;
                    n_slot       = {cur_eff, i_in_data.ch};
                    if (!i_in_data.empty_word) begin
                        child_re   = 1'b1;
                        n_mid_word = !i_in_data.last;
                    end else begin
                        n_mid_word = 1'b0;
                        if (ins_eff) begin
                            n_out_valid = 1'b1;
                            if (ovf_eff) begin
                                n_out = '{answer: 1'b0, table_full: 1'b1};
                            end else begin
                                mark_we    = 1'b1;
                                mark_waddr = cur_eff;
                                n_out      = '{answer: 1'b1, table_full: 1'b0};
                            end
                        end else if (exact_eff) begin
                            mark_re    = 1'b1;
                            mark_raddr = cur_eff;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out       = '{answer: !lost_eff, table_full: 1'b0};
                        end
                    end
                end
            end
            ST_CHILD: begin
                n_cursor     = cur_new;
                n_path_lost  = lost_new;
                n_overflowed = ovf_new;
                if (alloc_now) begin
                    child_we     = 1'b1;
                    child_wdata  = cur_new;
                    n_nodes_used = r_nodes_used + 1'b1;
                end
                if (r_last) begin
                    if (ins_word) begin
                        n_out_valid = 1'b1;
                        if (ovf_new) begin
                            n_out = '{answer: 1'b0, table_full: 1'b1};
                        end else begin
                            mark_we    = 1'b1;
                            mark_waddr = cur_new;
                            n_out      = '{answer: 1'b1, table_full: 1'b0};
                        end
                    end else if (exact_word) begin
                        mark_re    = 1'b1;
                        mark_raddr = cur_new;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = '{answer: !lost_new, table_full: 1'b0};
                    end
                end
            end
            ST_MARK: begin
                n_out_valid = 1'b1;
                n_out       = '{answer: !r_path_lost && r_mark_rdata, table_full: 1'b0};
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (child_we) begin
            r_child_mem[child_waddr] <= child_wdata;
        end
        if (child_re) begin
            r_child_rdata <= r_child_mem[child_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[mark_waddr] <= mark_wdata;
        end
        if (mark_re) begin
            r_mark_rdata <= r_mark_mem[mark_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_nodes_used <= (NW + 1)'(1);
            r_cursor     <= '0;
            r_path_lost  <= 1'b0;
            r_overflowed <= 1'b0;
            r_word_kind  <= KIND_INSERT;
            r_mid_word   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_nodes_used <= n_nodes_used;
            r_cursor     <= n_cursor;
            r_path_lost  <= n_path_lost;
            r_overflowed <= n_overflowed;
            r_word_kind  <= n_word_kind;
            r_mid_word   <= n_mid_word;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_last <= n_last;
        r_out  <= n_out;
    end

endmodule
